// ----- rtl/pdshr_pkg.sv -----
package pdshr_pkg;

    // Widest values the command fields can carry, fixed by the item fields
    // (device 3 bits, request count 6 bits) and by the largest history depth.
    localparam int DEV_W   = 3;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 6;
    localparam int WORD_W  = 16;
    localparam int AGE_W   = 5;

    // Input item kinds carried in tuser.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Word index of the poll enable register on the configuration port.
    localparam logic REG_POLL_ENABLED = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_READ,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [DEV_W-1:0]   dev;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic [WORD_W-1:0]  word;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

// ----- rtl/pdshr_cmd_fifo.sv -----
module pdshr_cmd_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pdshr_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output pdshr_pkg::cmd_t   head_cmd
);

    pdshr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/pdshr_front.sv -----
module pdshr_front
#(
    parameter int DEVICES = 4,
    parameter int DEPTH   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_enabled,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,
    input  logic              s_axis_tuser,
    input  logic              fifo_full,
    output logic              cmd_push,
    output pdshr_pkg::cmd_t   cmd
);

    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    logic [HW-1:0] head_reg  [DEVICES];
    logic [HW-1:0] head_next [DEVICES];
    logic [FW-1:0] fill_reg  [DEVICES];
    logic [FW-1:0] fill_next [DEVICES];

    logic                          accept;
    logic [pdshr_pkg::DEV_W-1:0]   dev;
    logic [pdshr_pkg::WORD_W-1:0]  word;
    logic [pdshr_pkg::CNT_W-1:0]   req;
    logic                          dev_ok;
    logic [DW-1:0]                 dev_sel;
    logic [HW-1:0]                 head;
    logic [HW-1:0]                 head_inc;
    logic [HW-1:0]                 head_prev;
    logic [FW-1:0]                 fill;
    logic [FW-1:0]                 fill_inc;
    logic [pdshr_pkg::CNT_W-1:0]   n_words;
    logic                          push_ok;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && !fifo_full;

    assign dev  = s_axis_tdata[2:0];
    assign word = s_axis_tdata[18:3];
    assign req  = s_axis_tdata[24:19];

    assign dev_ok  = ({1'b0, dev} < 4'(DEVICES));
    assign dev_sel = dev_ok ? dev[DW-1:0] : '0;
    assign head    = head_reg[dev_sel];
    assign fill    = fill_reg[dev_sel];

    assign head_inc  = (head == HW'(DEPTH - 1)) ? '0 : head + 1'b1;
    assign head_prev = (head == '0) ? HW'(DEPTH - 1) : head - 1'b1;
    assign fill_inc  = (fill == FW'(DEPTH)) ? fill : fill + 1'b1;
    assign n_words   = (9'(req) < 9'(fill)) ? req : pdshr_pkg::CNT_W'(fill);
    assign push_ok   = (s_axis_tuser == pdshr_pkg::MODE_PUSH) && poll_enabled && dev_ok;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        cmd_push  = 1'b0;
        cmd.kind  = pdshr_pkg::CMD_EMPTY;
        cmd.dev   = dev;
        cmd.idx   = pdshr_pkg::IDX_W'(head);
        cmd.count = n_words;
        cmd.word  = word;
        if (accept)
        begin
            if (s_axis_tuser == pdshr_pkg::MODE_PUSH)
            begin
                if (push_ok)
                begin
                    cmd_push           = 1'b1;
                    cmd.kind           = pdshr_pkg::CMD_PUSH;
                    head_next[dev_sel] = head_inc;
                    fill_next[dev_sel] = fill_inc;
                end
            end
            else
            begin
                cmd_push = 1'b1;
                if (!dev_ok || req == '0 || fill == '0)
                begin
                    cmd.kind = pdshr_pkg::CMD_EMPTY;
                end
                else
                begin
                    cmd.kind = pdshr_pkg::CMD_READ;
                    cmd.idx  = pdshr_pkg::IDX_W'(head_prev);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- rtl/pdshr_back.sv -----
module pdshr_back
#(
    parameter int DEVICES = 4,
    parameter int DEPTH   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  pdshr_pkg::cmd_t   cmd,
    output logic              cmd_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);

    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = $clog2(DEVICES * (2 ** HW));

    logic [pdshr_pkg::WORD_W-1:0] mem [DEVICES * (2 ** HW)];
    logic [pdshr_pkg::WORD_W-1:0] rd_data_reg;

    pdshr_pkg::back_state_t        state_reg;
    pdshr_pkg::back_state_t        state_next;
    logic [pdshr_pkg::DEV_W-1:0]   dev_reg;
    logic [pdshr_pkg::DEV_W-1:0]   dev_next;
    logic [HW-1:0]                 idx_reg;
    logic [HW-1:0]                 idx_next;
    logic [pdshr_pkg::CNT_W-1:0]   rem_reg;
    logic [pdshr_pkg::CNT_W-1:0]   rem_next;
    logic [pdshr_pkg::AGE_W-1:0]   age_reg;
    logic [pdshr_pkg::AGE_W-1:0]   age_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pdshr_pkg::AGE_W-1:0]   out_age_reg;
    logic [pdshr_pkg::AGE_W-1:0]   out_age_next;
    logic                          out_last_reg;
    logic                          out_last_next;
    logic                          out_nodata_reg;
    logic                          out_nodata_next;

    logic          out_free;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign wr_addr  = AW'({cmd.dev, cmd.idx[HW-1:0]});
    assign rd_addr  = AW'({dev_reg, idx_reg});

    always_comb
    begin
        state_next      = state_reg;
        dev_next        = dev_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        age_next        = age_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_age_next    = out_age_reg;
        out_last_next   = out_last_reg;
        out_nodata_next = out_nodata_reg;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        case (state_reg)
            pdshr_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        pdshr_pkg::CMD_PUSH:
                        begin
                            wr_en   = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        pdshr_pkg::CMD_EMPTY:
                        begin
                            if (out_free)
                            begin
                                cmd_pop         = 1'b1;
                                out_valid_next  = 1'b1;
                                out_age_next    = '0;
                                out_last_next   = 1'b1;
                                out_nodata_next = 1'b1;
                            end
                        end
                        pdshr_pkg::CMD_READ:
                        begin
                            cmd_pop    = 1'b1;
                            dev_next   = cmd.dev;
                            idx_next   = cmd.idx[HW-1:0];
                            rem_next   = cmd.count;
                            age_next   = '0;
                            state_next = pdshr_pkg::BK_READ;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            pdshr_pkg::BK_READ:
            begin
                if (out_free)
                begin
                    rd_en           = 1'b1;
                    out_valid_next  = 1'b1;
                    out_age_next    = age_reg;
                    out_last_next   = (rem_reg == pdshr_pkg::CNT_W'(1));
                    out_nodata_next = 1'b0;
                    age_next        = age_reg + 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    idx_next        = (idx_reg == '0) ? HW'(DEPTH - 1) : idx_reg - 1'b1;
                    if (rem_reg == pdshr_pkg::CNT_W'(1))
                    begin
                        state_next = pdshr_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pdshr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdshr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg        <= dev_next;
        idx_reg        <= idx_next;
        age_reg        <= age_next;
        out_age_reg    <= out_age_next;
        out_last_reg   <= out_last_next;
        out_nodata_reg <= out_nodata_next;
    end

    // History memory; the read register doubles as the output data register.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_age_reg, out_nodata_reg ? 16'h0000 : rd_data_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_nodata_reg;

endmodule

// ----- rtl/per_device_status_history_ring.sv -----
// Channel   Direction  Beat contents
// s_axis    in         tuser: mode; tdata: device, status_word, request_count
// m_axis    out        tdata: history_word, age; tlast: last; tuser: no_data
// apb       in/out     register 0 (byte address 0): poll_enabled, reset value 1
//
// The front accepts one beat per cycle while the two-entry command queue has
// room; it updates the per-device head and fill count at once.
// The back writes a push to the memory, answers an empty read with a single
// beat, and for a read of n words loads the start point and then sends the
// words newest first as m_axis takes them; it takes no new command until then.
// Reset clears heads, fill counts, the queue and the output; the history memory
// is not cleared, since only written entries are ever read.
// A stall on m_axis holds the back once it has a beat to send; the queue then fills and s_axis_tready drops.
module per_device_status_history_ring
#(
    parameter int DEVICES = 4,
    parameter int DEPTH   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: device[2:0], status_word[18:3], request_count[24:19].
    input  logic [31:0] s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: history_word[15:0], age[20:16].
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // Fields from bit 0: no_data.
    output logic        m_axis_tuser
);

    logic poll_enabled_reg;
    logic poll_enabled_next;
    logic reg_hit;

    logic            fifo_full;
    logic            fifo_not_empty;
    logic            cmd_push;
    logic            cmd_pop;
    pdshr_pkg::cmd_t front_cmd;
    pdshr_pkg::cmd_t back_cmd;

    // The register decode uses the word index; any address past register 0
    // reads as zero and ignores writes.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == pdshr_pkg::REG_POLL_ENABLED);
    assign prdata  = reg_hit ? {31'b0, poll_enabled_reg} : 32'b0;

    always_comb
    begin
        poll_enabled_next = poll_enabled_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            poll_enabled_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_enabled_reg <= 1'b1;
        end
        else
        begin
            poll_enabled_reg <= poll_enabled_next;
        end
    end

    // The front classifies each beat and queues a command; ignored pushes
    // queue nothing.
    pdshr_front #(
        .DEVICES (DEVICES),
        .DEPTH   (DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .poll_enabled  (poll_enabled_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .cmd_push      (cmd_push),
        .cmd           (front_cmd)
    );

    // Commands run in order, so a read always sees the pushes before it.
    pdshr_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (front_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .not_empty (fifo_not_empty),
        .head_cmd  (back_cmd)
    );

    pdshr_back #(
        .DEVICES (DEVICES),
        .DEPTH   (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (fifo_not_empty),
        .cmd           (back_cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // An empty answer is a single beat with a zero word and age.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[20:0] == 21'd0))
    else $error("no_data beat is not a lone zero beat");

    // Within a run the age steps by one from beat to beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && m_axis_tready && !m_axis_tlast) && m_axis_tvalid |->
            m_axis_tdata[20:16] == ($past(m_axis_tdata[20:16]) + 5'd1))
    else $error("age does not advance within a run");

    // A run starts at age zero after its predecessor ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && m_axis_tready && m_axis_tlast) && m_axis_tvalid |->
            m_axis_tdata[20:16] == 5'd0)
    else $error("run does not start at age zero");

endmodule

// ----- verif/tb_per_device_status_history_ring.sv -----
`timescale 1ns / 1ps

module tb_per_device_status_history_ring;

    // The block is built with its default sizes, and the local history model
    // below has the same sizes.
    localparam int NDEV   = 4;
    localparam int HDEPTH = 32;

    // Byte addresses on the configuration port. The spare address decodes to
    // no register, so a write there must leave poll_enabled alone.
    localparam logic [2:0] POLL_ADDR  = {pdshr_pkg::REG_POLL_ENABLED, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'b100;

    // Cycles allowed for a push to land in the memory after the last result
    // beat, and the number of quiet cycles that ends a hung run.
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic                         mode;
        logic [pdshr_pkg::DEV_W-1:0]  device;
        logic [pdshr_pkg::WORD_W-1:0] status_word;
        logic [pdshr_pkg::CNT_W-1:0]  request_count;
    } status_item_t;

    typedef struct packed {
        logic [pdshr_pkg::WORD_W-1:0] history_word;
        logic [pdshr_pkg::AGE_W-1:0]  age;
        logic                         last;
        logic                         no_data;
    } history_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0: device[2:0], status_word[18:3], request_count[24:19].
    logic [31:0] s_axis_tdata = '0;
    // Fields from bit 0: mode.
    logic        s_axis_tuser = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0: history_word[15:0], age[20:16].
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    // Fields from bit 0: no_data.
    logic        m_axis_tuser;

    per_device_status_history_ring #(
        .DEVICES (NDEV),
        .DEPTH   (HDEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the history: one ring per device, with its write head and
    // fill count, plus the poll enable as last written.
    logic [pdshr_pkg::WORD_W-1:0] hist_mem [NDEV][HDEPTH];
    int                           head_pos [NDEV];
    int                           fill_cnt [NDEV];
    bit                           poll_on;

    status_item_t  pending_items[$];
    history_beat_t expected_beats[$];

    status_item_t  on_wire;
    history_beat_t want_beat;

    // Sender and receiver pacing, changed by the stimulus between phases.
    int tx_gap_max    = 0;
    int tx_burst      = 0;
    int tx_gap        = 0;
    int rx_stall_pct  = 0;
    int rx_stall_max  = 1;
    int rx_hold       = 0;

    int mismatch_count = 0;
    int items_accepted = 0;
    int reads_accepted = 0;
    int beats_checked  = 0;
    int nodata_beats   = 0;
    int quiet_cycles   = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Applies one accepted item to the local history and queues the result
    // beats that it must produce.
    task automatic apply_status_item(input status_item_t it);
        history_beat_t b;
        int            dev;
        int            n;
        int            pos;
        dev = int'(it.device);
        if (it.mode == pdshr_pkg::MODE_PUSH)
        begin
            // Pushes are dropped while polling is off or for a device that
            // does not exist; otherwise they never produce a beat.
            if (poll_on && dev < NDEV)
            begin
                hist_mem[dev][head_pos[dev]] = it.status_word;
                head_pos[dev] = (head_pos[dev] + 1) % HDEPTH;
                if (fill_cnt[dev] < HDEPTH)
                    fill_cnt[dev]++;
            end
        end
        else if (dev >= NDEV || it.request_count == '0 || fill_cnt[dev] == 0)
        begin
            b.history_word = '0;
            b.age          = '0;
            b.last         = 1'b1;
            b.no_data      = 1'b1;
            expected_beats.push_back(b);
        end
        else
        begin
            // An oversized request is cut to what the ring holds; the walk
            // goes backward from the newest entry and wraps below zero.
            n = int'(it.request_count);
            if (n > fill_cnt[dev])
                n = fill_cnt[dev];
            pos = (head_pos[dev] + HDEPTH - 1) % HDEPTH;
            for (int k = 0; k < n; k++)
            begin
                b.history_word = hist_mem[dev][pos];
                b.age          = pdshr_pkg::AGE_W'(k);
                b.last         = (k == n - 1);
                b.no_data      = 1'b0;
                expected_beats.push_back(b);
                pos = (pos + HDEPTH - 1) % HDEPTH;
            end
        end
    endtask

    // Driver: hands out pending items in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_status_item(on_wire);
                items_accepted++;
                if (on_wire.mode == pdshr_pkg::MODE_READ)
                    reads_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    on_wire = pending_items.pop_front();
                    s_axis_tdata  <= {7'd0, on_wire.request_count, on_wire.status_word,
                                      on_wire.device};
                    s_axis_tuser  <= on_wire.mode;
                    s_axis_tvalid <= 1'b1;
                    if (tx_burst <= 1)
                    begin
                        tx_burst = $urandom_range(1, 8);
                        tx_gap   = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                    end
                    else
                    begin
                        tx_burst--;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest expectation and
    // stalls the output in runs of random length.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected",
                                    int'(m_axis_tdata), 0);
                end
                else
                begin
                    want_beat = expected_beats.pop_front();
                    beats_checked++;
                    if (want_beat.no_data)
                        nodata_beats++;
                    if (m_axis_tdata[15:0] !== want_beat.history_word)
                        report_mismatch("history_word", int'(m_axis_tdata[15:0]),
                                        int'(want_beat.history_word));
                    if (m_axis_tdata[20:16] !== want_beat.age)
                        report_mismatch("age", int'(m_axis_tdata[20:16]),
                                        int'(want_beat.age));
                    if (m_axis_tlast !== want_beat.last)
                        report_mismatch("last", int'(m_axis_tlast), int'(want_beat.last));
                    if (m_axis_tuser !== want_beat.no_data)
                        report_mismatch("no_data", int'(m_axis_tuser),
                                        int'(want_beat.no_data));
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                rx_hold = $urandom_range(0, rx_stall_max - 1);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run of cycles with no beat moving on either side means the
    // block has hung or lost results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles, %0d results still due",
                         QUIET_LIMIT, expected_beats.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic mode, input int dev, input int word, input int cnt);
        status_item_t it;
        it.mode          = mode;
        it.device        = pdshr_pkg::DEV_W'(dev);
        it.status_word   = pdshr_pkg::WORD_W'(word);
        it.request_count = pdshr_pkg::CNT_W'(cnt);
        pending_items.push_back(it);
    endtask

    // Mostly pushes and reads to real devices, with a few invalid devices,
    // zero requests and oversized requests mixed in.
    task automatic queue_random(input int count, input int push_pct);
        status_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.mode = ($urandom_range(0, 99) < push_pct) ? pdshr_pkg::MODE_PUSH
                                                         : pdshr_pkg::MODE_READ;
            if ($urandom_range(0, 9) < 9)
                it.device = pdshr_pkg::DEV_W'($urandom_range(0, NDEV - 1));
            else
                it.device = pdshr_pkg::DEV_W'($urandom_range(NDEV, 7));
            it.status_word = pdshr_pkg::WORD_W'($urandom);
            case ($urandom_range(0, 9))
                0:       it.request_count = '0;
                1:       it.request_count = pdshr_pkg::CNT_W'(HDEPTH);
                default: it.request_count = pdshr_pkg::CNT_W'($urandom_range(1, 12));
            endcase
            pending_items.push_back(it);
        end
    endtask

    // Blocks until every item is accepted and every result has come back,
    // then leaves room for a trailing push to finish.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write with a setup and an access phase; the local copy follows at the access edge.
    // A read of the poll enable register, in the same two phases, follows and is checked.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == POLL_ADDR)
            poll_on = data[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= POLL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, poll_on})
            report_mismatch("poll_enabled read", int'(prdata), int'(poll_on));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    int wrap_dev;

    initial
    begin
        for (int d = 0; d < NDEV; d++)
        begin
            head_pos[d] = 0;
            fill_cnt[d] = 0;
        end
        poll_on = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, polling on from reset. Reads of an empty ring, of a
        // nonexistent device and with a zero count must each give one
        // no_data beat; an oversized request returns only what was written.
        queue_item(pdshr_pkg::MODE_READ, 0, 16'h0000, 5);
        queue_item(pdshr_pkg::MODE_READ, 7, 16'hFFFF, 1);
        queue_item(pdshr_pkg::MODE_PUSH, 0, 16'h0000, 0);
        queue_item(pdshr_pkg::MODE_PUSH, 0, 16'hFFFF, 63);
        queue_item(pdshr_pkg::MODE_PUSH, 0, 16'hA5A5, 32);
        queue_item(pdshr_pkg::MODE_READ, 0, 16'h0000, 0);
        queue_item(pdshr_pkg::MODE_READ, 0, 16'h0000, 2);
        queue_item(pdshr_pkg::MODE_READ, 0, 16'hFFFF, HDEPTH);
        queue_item(pdshr_pkg::MODE_PUSH, 5, 16'h1234, 0);
        queue_item(pdshr_pkg::MODE_READ, 5, 16'h0000, 3);
        queue_item(pdshr_pkg::MODE_PUSH, 7, 16'hFFFF, 0);
        queue_item(pdshr_pkg::MODE_PUSH, 3, 16'h5A5A, 0);
        queue_item(pdshr_pkg::MODE_READ, 3, 16'h0000, 1);
        queue_item(pdshr_pkg::MODE_READ, 1, 16'h0000, HDEPTH);
        queue_item(pdshr_pkg::MODE_PUSH, 1, 16'h8001, 0);
        queue_item(pdshr_pkg::MODE_PUSH, 2, 16'h7FFE, 0);
        queue_item(pdshr_pkg::MODE_READ, 2, 16'h0000, 1);
        queue_item(pdshr_pkg::MODE_READ, 1, 16'hFFFF, 4);
        wait_idle();

        // Polling on, no idling on either side.
        apb_write(POLL_ADDR, 32'd1);
        queue_random(28, 60);
        wait_idle();

        // Polling off: pushes must leave every ring untouched. A write to the
        // spare address must not turn polling back on.
        apb_write(POLL_ADDR, 32'd0);
        apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
        tx_gap_max   = 6;
        rx_stall_pct = 20;
        rx_stall_max = 6;
        queue_random(16, 60);
        wait_idle();

        // Polling back on. One device gets more pushes than its ring holds so
        // that the head wraps and the fill count saturates, then is read in
        // full and then for its newest entry alone.
        apb_write(POLL_ADDR, 32'd1);
        tx_gap_max   = 3;
        rx_stall_pct = 35;
        rx_stall_max = 12;
        wrap_dev = $urandom_range(0, NDEV - 1);
        for (int i = 0; i < HDEPTH + 4; i++)
            queue_item(pdshr_pkg::MODE_PUSH, wrap_dev, $urandom, 0);
        queue_item(pdshr_pkg::MODE_READ, wrap_dev, 0, HDEPTH);
        queue_item(pdshr_pkg::MODE_READ, wrap_dev, 0, 1);
        wait_idle();

        // Heavy idling on both sides, reads weighted up.
        tx_gap_max   = 12;
        rx_stall_pct = 50;
        rx_stall_max = 16;
        queue_random(20, 45);
        wait_idle();

        $display("Run covered %0d items (%0d reads), %0d result beats of which %0d no_data,",
                 items_accepted, reads_accepted, beats_checked, nodata_beats);
        $display("with polling toggled, a spare-address write and a ring wrap on device %0d.",
                 wrap_dev);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pdshr_pkg.sv
rtl/pdshr_cmd_fifo.sv
rtl/pdshr_front.sv
rtl/pdshr_back.sv
rtl/per_device_status_history_ring.sv
verif/tb_per_device_status_history_ring.sv
